@@ hdl/assert_macros.svh @@
// assertion macros for the rtl files of the rmc parser
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ hdl/gprmc_pkg.sv @@
// shared types and constants of the rmc sentence parser
// no dependencies; used by gprmc_line_parser and gprmc_sentence_parser
package gprmc_pkg;

    // field capacities in characters
    localparam int COORD_CHARS = 11;
    localparam int SPEED_CHARS = 4;
    localparam int TIME_CHARS  = 6;
    localparam int DATE_CHARS  = 6;
    localparam int COORD_SLOTS = 11;
    localparam int SPEED_SLOTS = 4;
    localparam int HEAD_LEN    = 6;

    // ascii codes
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_N       = 8'h4E;
    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_E       = 8'h45;
    localparam logic [7:0] CHAR_W       = 8'h57;

    // sentence head "$GPRMC"
    localparam logic [7:0] HEAD_TEXT [HEAD_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

    // field numbers counted by commas
    localparam logic [3:0] FIELD_TIME    = 4'd1;
    localparam logic [3:0] FIELD_STATUS  = 4'd2;
    localparam logic [3:0] FIELD_LAT     = 4'd3;
    localparam logic [3:0] FIELD_LAT_HEM = 4'd4;
    localparam logic [3:0] FIELD_LON     = 4'd5;
    localparam logic [3:0] FIELD_LON_HEM = 4'd6;
    localparam logic [3:0] FIELD_SPEED   = 4'd7;
    localparam logic [3:0] FIELD_DATE    = 4'd9;
    localparam logic [3:0] COUNT_MAX     = 4'd15;

    // hemisphere codes
    localparam logic [1:0] HEMI_NONE  = 2'd0;
    localparam logic [1:0] HEMI_FIRST = 2'd1;
    localparam logic [1:0] HEMI_SECOND = 2'd2;

    // one parsed sentence
    typedef struct packed {
        logic [47:0] utc_time_text;
        logic        fix_valid;
        logic [63:0] lat_text_high;
        logic [23:0] lat_text_low;
        logic [1:0]  lat_hemisphere;
        logic [63:0] lon_text_high;
        logic [23:0] lon_text_low;
        logic [1:0]  lon_hemisphere;
        logic [31:0] speed_text;
        logic [47:0] utc_date_text;
    } gprmc_result_t;

endpackage

@@ hdl/gprmc_sentence_parser.sv @@
// top level of the rmc sentence parser: input register, line parser, result register
// depends on gprmc_pkg, gprmc_line_parser and assert_macros.svh
//
// usage
// - input channel: rx_byte with in_valid / in_stall; one byte per transaction,
//   accepted at a clock edge with in_valid high and in_stall low
// - output channel: the ten result fields with out_valid / out_stall; one
//   transaction per newline that ends a line starting with "$GPRMC"
// - every byte is first held in the input register, then parsed by the line parser,
//   which updates its stores and, on a newline, loads the result register
// - the newline passes the input register, then the line parser loads the result
//   register and out_valid rises, so the result can be taken from it
// - throughput is one byte per cycle while out_stall is low; the single
//   input register and the result register set that figure
// - while a result waits under out_stall, the byte in the input register
//   waits too and in_stall rises; stalled outputs hold their values
// - reset clears the line state to line start, all stores to zero and both
//   registers to empty; no clearing pass follows
`include "assert_macros.svh"

module gprmc_sentence_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [47:0] utc_time_text,
    output logic        fix_valid,
    output logic [63:0] lat_text_high,
    output logic [23:0] lat_text_low,
    output logic [1:0]  lat_hemisphere,
    output logic [63:0] lon_text_high,
    output logic [23:0] lon_text_low,
    output logic [1:0]  lon_hemisphere,
    output logic [31:0] speed_text,
    output logic [47:0] utc_date_text
);

    logic                     s1_valid_reg;
    logic [7:0]               s1_byte_reg;
    logic                     out_valid_reg;
    gprmc_pkg::gprmc_result_t out_reg;
    logic                     out_free;
    logic                     s1_fire;
    logic                     in_take;
    logic                     hit;
    gprmc_pkg::gprmc_result_t result;

    // handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || s1_fire)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // line parser
    gprmc_line_parser u_line_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_fire),
        .rx_byte (s1_byte_reg),
        .hit     (hit),
        .result  (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            out_reg <= result;
        end
    end

    // outputs
    assign out_valid      = out_valid_reg;
    assign utc_time_text  = out_reg.utc_time_text;
    assign fix_valid      = out_reg.fix_valid;
    assign lat_text_high  = out_reg.lat_text_high;
    assign lat_text_low   = out_reg.lat_text_low;
    assign lat_hemisphere = out_reg.lat_hemisphere;
    assign lon_text_high  = out_reg.lon_text_high;
    assign lon_text_low   = out_reg.lon_text_low;
    assign lon_hemisphere = out_reg.lon_hemisphere;
    assign speed_text     = out_reg.speed_text;
    assign utc_date_text  = out_reg.utc_date_text;

    // checks
    `ASSERT_CLK(a_hit_loads_out, hit |=> out_valid_reg, "parsed sentence did not reach output")
    `ASSERT_NEVER(a_hit_while_full, hit && !out_free, "result would overwrite a waiting one")
    `ASSERT_NEVER(a_stall_without_byte, in_stall && !s1_valid_reg, "input stalled while empty")
    `ASSERT_NEVER(a_bad_hemisphere, out_valid_reg &&
        (lat_hemisphere == 2'd3 || lon_hemisphere == 2'd3), "hemisphere code out of range")

endmodule

@@ hdl/gprmc_line_parser.sv @@
// per-byte line state and field capture of the rmc parser
// depends on gprmc_pkg
module gprmc_line_parser
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               rx_byte,
    output logic                     hit,
    output gprmc_pkg::gprmc_result_t result
);

    logic [2:0] pos_reg, pos_next;
    logic       prefix_reg, prefix_next;
    logic [3:0] field_reg, field_next;
    logic [3:0] index_reg, index_next;
    logic [7:0] time_reg  [gprmc_pkg::TIME_CHARS];
    logic [7:0] time_next [gprmc_pkg::TIME_CHARS];
    logic       status_reg, status_next;
    logic [7:0] lat_reg   [gprmc_pkg::COORD_SLOTS];
    logic [7:0] lat_next  [gprmc_pkg::COORD_SLOTS];
    logic [1:0] lat_hem_reg, lat_hem_next;
    logic [7:0] lon_reg   [gprmc_pkg::COORD_SLOTS];
    logic [7:0] lon_next  [gprmc_pkg::COORD_SLOTS];
    logic [1:0] lon_hem_reg, lon_hem_next;
    logic [7:0] speed_reg  [gprmc_pkg::SPEED_SLOTS];
    logic [7:0] speed_next [gprmc_pkg::SPEED_SLOTS];
    logic [7:0] date_reg  [gprmc_pkg::DATE_CHARS];
    logic [7:0] date_next [gprmc_pkg::DATE_CHARS];

    // next line state for one byte
    always_comb
    begin
        pos_next     = pos_reg;
        prefix_next  = prefix_reg;
        field_next   = field_reg;
        index_next   = index_reg;
        time_next    = time_reg;
        status_next  = status_reg;
        lat_next     = lat_reg;
        lat_hem_next = lat_hem_reg;
        lon_next     = lon_reg;
        lon_hem_next = lon_hem_reg;
        speed_next   = speed_reg;
        date_next    = date_reg;
        hit          = 1'b0;
        if (step)
        begin
            if (rx_byte == gprmc_pkg::CHAR_NEWLINE)
            begin
                // end of line: report if the head matched, then back to line start
                hit          = prefix_reg && (pos_reg == 3'(gprmc_pkg::HEAD_LEN));
                pos_next     = 3'd0;
                prefix_next  = 1'b1;
                field_next   = 4'd0;
                index_next   = 4'd0;
                status_next  = 1'b0;
                lat_hem_next = gprmc_pkg::HEMI_NONE;
                lon_hem_next = gprmc_pkg::HEMI_NONE;
                for (int k = 0; k < gprmc_pkg::TIME_CHARS; k++)
                begin
                    time_next[k] = 8'd0;
                end
                for (int k = 0; k < gprmc_pkg::COORD_SLOTS; k++)
                begin
                    lat_next[k] = 8'd0;
                    lon_next[k] = 8'd0;
                end
                for (int k = 0; k < gprmc_pkg::SPEED_SLOTS; k++)
                begin
                    speed_next[k] = 8'd0;
                end
                for (int k = 0; k < gprmc_pkg::DATE_CHARS; k++)
                begin
                    date_next[k] = 8'd0;
                end
            end
            else
            begin
                // head check over the first characters of the line
                if (pos_reg < 3'(gprmc_pkg::HEAD_LEN))
                begin
                    if (rx_byte != gprmc_pkg::HEAD_TEXT[pos_reg])
                    begin
                        prefix_next = 1'b0;
                    end
                    pos_next = pos_reg + 3'd1;
                end
                if (rx_byte == gprmc_pkg::CHAR_COMMA)
                begin
                    if (field_reg != gprmc_pkg::COUNT_MAX)
                    begin
                        field_next = field_reg + 4'd1;
                    end
                    index_next = 4'd0;
                end
                else
                begin
                    // capture into the current field
                    case (field_reg)
                        gprmc_pkg::FIELD_TIME:
                        begin
                            for (int k = 0; k < gprmc_pkg::TIME_CHARS; k++)
                            begin
                                if (index_reg == 4'(k)) time_next[k] = rx_byte;
                            end
                        end
                        gprmc_pkg::FIELD_STATUS:
                        begin
                            status_next = (rx_byte == gprmc_pkg::CHAR_A);
                        end
                        gprmc_pkg::FIELD_LAT:
                        begin
                            for (int k = 0; k < gprmc_pkg::COORD_CHARS; k++)
                            begin
                                if (index_reg == 4'(k)) lat_next[k] = rx_byte;
                            end
                        end
                        gprmc_pkg::FIELD_LAT_HEM:
                        begin
                            if (rx_byte == gprmc_pkg::CHAR_N)
                                lat_hem_next = gprmc_pkg::HEMI_FIRST;
                            else if (rx_byte == gprmc_pkg::CHAR_S)
                                lat_hem_next = gprmc_pkg::HEMI_SECOND;
                        end
                        gprmc_pkg::FIELD_LON:
                        begin
                            for (int k = 0; k < gprmc_pkg::COORD_CHARS; k++)
                            begin
                                if (index_reg == 4'(k)) lon_next[k] = rx_byte;
                            end
                        end
                        gprmc_pkg::FIELD_LON_HEM:
                        begin
                            if (rx_byte == gprmc_pkg::CHAR_E)
                                lon_hem_next = gprmc_pkg::HEMI_FIRST;
                            else if (rx_byte == gprmc_pkg::CHAR_W)
                                lon_hem_next = gprmc_pkg::HEMI_SECOND;
                        end
                        gprmc_pkg::FIELD_SPEED:
                        begin
                            for (int k = 0; k < gprmc_pkg::SPEED_CHARS; k++)
                            begin
                                if (index_reg == 4'(k)) speed_next[k] = rx_byte;
                            end
                        end
                        gprmc_pkg::FIELD_DATE:
                        begin
                            for (int k = 0; k < gprmc_pkg::DATE_CHARS; k++)
                            begin
                                if (index_reg == 4'(k)) date_next[k] = rx_byte;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (index_reg != gprmc_pkg::COUNT_MAX)
                    begin
                        index_next = index_reg + 4'd1;
                    end
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 3'd0;
            prefix_reg  <= 1'b1;
            field_reg   <= 4'd0;
            index_reg   <= 4'd0;
            status_reg  <= 1'b0;
            lat_hem_reg <= gprmc_pkg::HEMI_NONE;
            lon_hem_reg <= gprmc_pkg::HEMI_NONE;
            for (int k = 0; k < gprmc_pkg::TIME_CHARS; k++)
            begin
                time_reg[k] <= 8'd0;
            end
            for (int k = 0; k < gprmc_pkg::COORD_SLOTS; k++)
            begin
                lat_reg[k] <= 8'd0;
                lon_reg[k] <= 8'd0;
            end
            for (int k = 0; k < gprmc_pkg::SPEED_SLOTS; k++)
            begin
                speed_reg[k] <= 8'd0;
            end
            for (int k = 0; k < gprmc_pkg::DATE_CHARS; k++)
            begin
                date_reg[k] <= 8'd0;
            end
        end
        else
        begin
            pos_reg     <= pos_next;
            prefix_reg  <= prefix_next;
            field_reg   <= field_next;
            index_reg   <= index_next;
            status_reg  <= status_next;
            lat_hem_reg <= lat_hem_next;
            lon_hem_reg <= lon_hem_next;
            time_reg    <= time_next;
            lat_reg     <= lat_next;
            lon_reg     <= lon_next;
            speed_reg   <= speed_next;
            date_reg    <= date_next;
        end
    end

    // pack the stores, first character in the top byte
    always_comb
    begin
        result.fix_valid      = status_reg;
        result.lat_hemisphere = lat_hem_reg;
        result.lon_hemisphere = lon_hem_reg;
        for (int k = 0; k < gprmc_pkg::TIME_CHARS; k++)
        begin
            result.utc_time_text[(gprmc_pkg::TIME_CHARS - k) * 8 - 1 -: 8] = time_reg[k];
        end
        for (int k = 0; k < gprmc_pkg::DATE_CHARS; k++)
        begin
            result.utc_date_text[(gprmc_pkg::DATE_CHARS - k) * 8 - 1 -: 8] = date_reg[k];
        end
        for (int k = 0; k < 8; k++)
        begin
            result.lat_text_high[(8 - k) * 8 - 1 -: 8] = lat_reg[k];
            result.lon_text_high[(8 - k) * 8 - 1 -: 8] = lon_reg[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            result.lat_text_low[(3 - k) * 8 - 1 -: 8] = lat_reg[8 + k];
            result.lon_text_low[(3 - k) * 8 - 1 -: 8] = lon_reg[8 + k];
        end
        for (int k = 0; k < gprmc_pkg::SPEED_SLOTS; k++)
        begin
            result.speed_text[(gprmc_pkg::SPEED_SLOTS - k) * 8 - 1 -: 8] = speed_reg[k];
        end
    end

endmodule
